>>> design/aoc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants of the object tag table
// Widths, command codes and the structs handed between the cells and the
// top level.
// ----------------------------------------------------------------------------
package aoc_pkg;

   // field widths
   localparam int KEY_W      = 64;
   localparam int SIZE_W     = 20;
   localparam int STAMP_W    = 31;
   localparam int LINE_OUT_W = 4;
   // line index width, wide enough for the largest table of 64 lines
   localparam int IDX_W      = 6;

   localparam int LINES_DEFAULT = 10;

   localparam logic [STAMP_W-1:0] STAMP_MAX      = '1;
   localparam logic [SIZE_W-1:0]  MAX_SIZE_RESET = 20'd102400;

   // request commands
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // register index decoded from the address word
   localparam logic REG_MAX_SIZE = 1'b0;

   // search token that walks along the row of lines
   typedef struct packed {
      logic               active;
      logic               cmd;
      logic               ins_ok;
      logic [KEY_W-1:0]   key;
      logic [SIZE_W-1:0]  size;
      logic               hit;
      logic [IDX_W-1:0]   hit_line;
      logic [SIZE_W-1:0]  hit_size;
      logic               empty_found;
      logic [IDX_W-1:0]   empty_line;
      logic [STAMP_W-1:0] min_stamp;
      logic [IDX_W-1:0]   min_line;
   } probe_type;

   // line fill data broadcast to every line
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
      logic [SIZE_W-1:0]  size;
   } fill_type;

endpackage : aoc_pkg
`default_nettype wire

>>> design/aoc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aoc_req_if: request channel
// Valid/ready channel carrying a lookup or insert request.
// ----------------------------------------------------------------------------
interface aoc_req_if import aoc_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [KEY_W-1:0]  key;
   logic [SIZE_W-1:0] object_size;

   modport source (output valid, cmd, key, object_size, input ready);
   modport sink   (input valid, cmd, key, object_size, output ready);

endinterface : aoc_req_if
`default_nettype wire

>>> design/aoc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aoc_rsp_if: result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface aoc_rsp_if import aoc_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [LINE_OUT_W-1:0] line;
   logic [SIZE_W-1:0]     stored_size;
   logic                  accepted;
   logic                  evicted;

   modport source (output valid, hit, line, stored_size, accepted, evicted, input ready);
   modport sink   (input valid, hit, line, stored_size, accepted, evicted, output ready);

endinterface : aoc_rsp_if
`default_nettype wire

>>> design/aoc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aoc_cell: one line of the tag table
// Holds valid, key, stamp and size of one line, updates the passing search
// token against its own line and registers it towards the next cell.
// ----------------------------------------------------------------------------
module aoc_cell import aoc_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire probe_type probe_i,
   output probe_type      probe_o,
   input  wire logic      wr_en_i,
   input  wire fill_type  wr_i,
   output logic           valid_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam bit FIRST = (INDEX == 0);

   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [SIZE_W-1:0]  size_ff;
   probe_type          probe_ff;
   probe_type          probe_in;

   // compare the token against this line
   always_comb begin
      probe_in = probe_i;
      if (probe_i.active) begin
         if (probe_i.cmd == CMD_LOOKUP) begin
            if (!probe_i.hit && valid_ff && (key_ff == probe_i.key)) begin
               probe_in.hit      = 1'b1;
               probe_in.hit_line = MY_IDX;
               probe_in.hit_size = size_ff;
            end
         end else begin
            // first empty line wins
            if (!valid_ff && !probe_i.empty_found) begin
               probe_in.empty_found = 1'b1;
               probe_in.empty_line  = MY_IDX;
            end
            // oldest line, strict compare keeps the lower index on a tie
            if (valid_ff && (FIRST || (stamp_ff < probe_i.min_stamp))) begin
               probe_in.min_stamp = stamp_ff;
               probe_in.min_line  = MY_IDX;
            end
         end
      end
   end

   // token stage towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   // line valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en_i) begin
         valid_ff <= 1'b1;
      end
   end

   // line contents
   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         key_ff   <= wr_i.key;
         stamp_ff <= wr_i.stamp;
         size_ff  <= wr_i.size;
      end
   end

   assign probe_o = probe_ff;
   assign valid_o = valid_ff;

endmodule : aoc_cell
`default_nettype wire

>>> design/assoc_object_cache_oldest_insert_replace_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// assoc_object_cache_oldest_insert_replace_unit: object tag table
// Fully associative table of LINES lines with oldest-insert replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries a lookup (cmd 0) or an insert (cmd 1) of a 64-bit key;
//   rsp_ch returns one result per request: hit, line and stored size for a
//   lookup, line, accepted and evicted for an insert.
//   The APB port holds the size limit at byte address 0; inserts above it
//   are refused and leave the table untouched.
// Timing:
//   a request walks the row of LINES line cells, one cell per cycle, is
//   captured at the end of the row and settled in the done state once the
//   output register is free; its result is then registered. One request is
//   in flight at a time, so a new request is taken only after the last one
//   is settled. The walk length is set by the cell chain.
//   A finished result waits in the output register while the next request
//   is taken; a further result is held back until that register is read.
// Reset:
//   synchronous, clears all line valid flags, the stamp counter and the
//   register to its default of 102400.
// ----------------------------------------------------------------------------
module assoc_object_cache_oldest_insert_replace_unit import aoc_pkg::*; #(
   parameter int LINES = LINES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   aoc_req_if.sink          req_ch,
   aoc_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [SIZE_W-1:0]     max_size_ff;
   logic [STAMP_W-1:0]    stamp_ctr_ff;
   logic [STAMP_W-1:0]    stamp_next;
   probe_type             done_ff;
   probe_type             entry;
   probe_type             chain [LINES+1];
   logic [LINES-1:0]      line_valid;
   logic [LINES-1:0]      cell_wr_en;
   fill_type              fill;
   logic                  req_take;
   logic                  out_free;
   logic                  finish;
   logic                  is_ins;
   logic                  wr_go;
   logic [IDX_W-1:0]      pick;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [LINE_OUT_W-1:0] rsp_line_ff;
   logic [SIZE_W-1:0]     rsp_size_ff;
   logic                  rsp_accepted_ff;
   logic                  rsp_evicted_ff;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX_SIZE) ? 32'(max_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_SIZE)) begin
         max_size_ff <= pwdata[SIZE_W-1:0];
      end
   end

   // request entry into the first cell
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      entry             = '0;
      entry.active      = req_take;
      entry.cmd         = req_ch.cmd;
      entry.ins_ok      = (req_ch.object_size <= max_size_ff);
      entry.key         = req_ch.key;
      entry.size        = req_ch.object_size;
   end

   assign chain[0] = entry;

   // row of line cells
   for (genvar i = 0; i < LINES; i++) begin : g_cell
      assign cell_wr_en[i] = wr_go && (pick == IDX_W'(i));

      aoc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .probe_i (chain[i]),
         .probe_o (chain[i+1]),
         .wr_en_i (cell_wr_en[i]),
         .wr_i    (fill),
         .valid_o (line_valid[i])
      );
   end

   // capture the token leaving the last cell
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && chain[LINES].active) begin
         done_ff <= chain[LINES];
      end
   end

   // settle the request
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign finish     = (state_ff == ST_DONE) && out_free;
   assign is_ins     = (done_ff.cmd == CMD_INSERT);
   assign wr_go      = finish && is_ins && done_ff.ins_ok;
   assign pick       = done_ff.empty_found ? done_ff.empty_line : done_ff.min_line;
   assign stamp_next = (stamp_ctr_ff == STAMP_MAX) ? stamp_ctr_ff : stamp_ctr_ff + 1'b1;

   always_comb begin
      fill.key   = done_ff.key;
      fill.stamp = stamp_next;
      fill.size  = done_ff.size;
   end

   // stamp counter
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ctr_ff <= '0;
      end else if (wr_go) begin
         stamp_ctr_ff <= stamp_next;
      end
   end

   // control sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[LINES].active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff      <= !is_ins && done_ff.hit;
         rsp_size_ff     <= (!is_ins && done_ff.hit) ? done_ff.hit_size : '0;
         rsp_accepted_ff <= is_ins && done_ff.ins_ok;
         rsp_evicted_ff  <= is_ins && done_ff.ins_ok && !done_ff.empty_found;
         if (is_ins) begin
            rsp_line_ff <= done_ff.ins_ok ? pick[LINE_OUT_W-1:0] : '0;
         end else begin
            rsp_line_ff <= done_ff.hit ? done_ff.hit_line[LINE_OUT_W-1:0] : '0;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.line        = rsp_line_ff;
   assign rsp_ch.stored_size = rsp_size_ff;
   assign rsp_ch.accepted    = rsp_accepted_ff;
   assign rsp_ch.evicted     = rsp_evicted_ff;

`ifndef SYNTHESIS
   logic [LINES-1:0] probe_act;

   for (genvar j = 0; j < LINES; j++) begin : g_act
      assign probe_act[j] = chain[j+1].active;
   end

   // never more than one token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_act))
      else $error("more than one request token in the cell row");

   // a taken request enters the first cell next cycle
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_take |=> probe_act[0])
      else $error("taken request did not enter the first cell");

   // replacement only when every line holds data
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (wr_go && !done_ff.empty_found) |-> (&line_valid))
      else $error("line replaced while an empty line exists");

   // no request taken while one is still in the row
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (|probe_act) |-> !req_take)
      else $error("request taken while another is in flight");

   // a result is either a lookup or an insert outcome
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_accepted_ff))
      else $error("result reports both hit and accepted");
`endif

endmodule : assoc_object_cache_oldest_insert_replace_unit
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: object tag table with oldest-insert replacement
// Drives lookups and inserts of 64-bit keys through the request channel and
// programs the size limit over the APB port. An in-bench copy of the table
// predicts each result, and a checker compares the results in arrival order.
// The sender works in bursts with random gaps. The receiver stalls on a
// pattern of its own, and once it holds off long enough to back up the
// request path.
// ----------------------------------------------------------------------------
module testbench;
   import aoc_pkg::*;

   localparam int LINES          = LINES_DEFAULT;
   localparam int WALK_CYCLES    = LINES + 2;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int POOL           = 14;
   localparam int LONG_HOLD      = 400;

   localparam logic [31:0]       STAMP_LIMIT = 32'h7FFF_FFFF;
   localparam logic [KEY_W-1:0]  KEY_ONES    = {KEY_W{1'b1}};
   localparam logic [SIZE_W-1:0] SIZE_ONES   = {SIZE_W{1'b1}};
   // a register index that the block does not decode
   localparam logic              REG_UNUSED  = 1'b1;

   typedef struct packed {
      logic                  hit;
      logic [LINE_OUT_W-1:0] line;
      logic [SIZE_W-1:0]     stored_size;
      logic                  accepted;
      logic                  evicted;
   } outcome_type;

   typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   aoc_req_if req_ch ();
   aoc_rsp_if rsp_ch ();

   assoc_object_cache_oldest_insert_replace_unit #(.LINES(LINES)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow copy of the tag table
   logic              tag_valid [LINES];
   logic [KEY_W-1:0]  tag_key   [LINES];
   logic [31:0]       tag_stamp [LINES];
   logic [SIZE_W-1:0] tag_size  [LINES];
   logic [31:0]       stamp_count;
   logic [SIZE_W-1:0] size_limit;

   outcome_type      pending_results [$];
   logic [KEY_W-1:0] key_pool [POOL];
   int               error_count   = 0;
   int               burst_left    = 0;
   int               stall_request = 0;
   bit               offering      = 0;
   bit               gapless       = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shadow table update for one taken request
   function automatic outcome_type apply_request(input logic c, input logic [KEY_W-1:0] k,
                                                 input logic [SIZE_W-1:0] s);
      outcome_type o;
      int          pick;
      o = '0;
      if (c == CMD_LOOKUP) begin
         for (int i = 0; i < LINES; i++) begin
            if (!o.hit && tag_valid[i] && tag_key[i] == k) begin
               o.hit         = 1'b1;
               o.line        = LINE_OUT_W'(i);
               o.stored_size = tag_size[i];
            end
         end
      end else if (s <= size_limit) begin
         if (stamp_count < STAMP_LIMIT) stamp_count++;
         pick = -1;
         for (int i = 0; i < LINES; i++) begin
            if (pick < 0 && !tag_valid[i]) pick = i;
         end
         // table full: oldest stamp goes, lowest index on a tie
         if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < LINES; i++) begin
               if (tag_stamp[i] < tag_stamp[pick]) pick = i;
            end
            o.evicted = 1'b1;
         end
         tag_valid[pick] = 1'b1;
         tag_key[pick]   = k;
         tag_stamp[pick] = stamp_count;
         tag_size[pick]  = s;
         o.accepted      = 1'b1;
         o.line          = LINE_OUT_W'(pick);
      end
      return o;
   endfunction

   function automatic string fmt_outcome(input outcome_type o);
      return $sformatf("hit=%0d line=%0d stored_size=%0d accepted=%0d evicted=%0d",
                       o.hit, o.line, o.stored_size, o.accepted, o.evicted);
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // one request through the request channel, bursts separated by gaps unless gapless is set
   task automatic send_request(input logic c, input logic [KEY_W-1:0] k,
                               input logic [SIZE_W-1:0] s);
      if (burst_left <= 0 && !gapless) begin
         if (offering) begin
            req_ch.valid <= 1'b0;
            offering = 0;
         end
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.key         <= k;
      req_ch.object_size <= s;
      offering = 1;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(apply_request(c, k, s));
      burst_left--;
   endtask

   // stop offering and let every outstanding request come back
   task automatic wait_idle();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (WALK_CYCLES) @(posedge clock);
   endtask

   // apb transfer: setup cycle, then access cycle until pready
   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // register write while idle, then read back the size limit
   task automatic write_register(input logic idx, input logic [31:0] data);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, {idx, 2'b00}, data, rd);
      if (idx == REG_MAX_SIZE) size_limit = data[SIZE_W-1:0];
      csr_access(1'b0, {REG_MAX_SIZE, 2'b00}, 32'd0, rd);
      if (rd !== 32'(size_limit))
         flag_error($sformatf("size limit read expected %0d got %0d", size_limit, rd));
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SIZE_ONES;
         2:       return size_limit;
         3:       return (size_limit == SIZE_ONES) ? SIZE_ONES : size_limit + 1'b1;
         4:       return SIZE_W'($urandom);
         default: return SIZE_W'($urandom_range(0, size_limit));
      endcase
   endfunction

   // keys for one phase, the extremes among them
   task automatic refill_pool();
      for (int i = 0; i < POOL; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
   endtask

   // mixed lookups and inserts, mostly on a small key pool so lines get hit
   task automatic run_traffic(input int count);
      logic             c;
      logic [KEY_W-1:0] k;
      for (int n = 0; n < count; n++) begin
         c = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
         if ($urandom_range(0, 99) < 82) k = key_pool[$urandom_range(0, POOL-1)];
         else k = {$urandom, $urandom};
         send_request(c, k, pick_size());
      end
   endtask

   // empty table: every lookup misses, size ignored
   task automatic test_empty_lookups();
      send_request(CMD_LOOKUP, '0, SIZE_ONES);
      send_request(CMD_LOOKUP, KEY_ONES, '0);
   endtask

   // default limit: sizes just over and at the limit, both size extremes
   task automatic test_reset_limit();
      send_request(CMD_INSERT, 64'h1234_5678_9ABC_DEF0, MAX_SIZE_RESET + 1'b1);
      send_request(CMD_INSERT, 64'h0FED_CBA9_8765_4321, SIZE_ONES);
      send_request(CMD_INSERT, '0, MAX_SIZE_RESET);
      send_request(CMD_INSERT, 64'h5555_5555_5555_5555, '0);
   endtask

   // fill every line, replace the oldest, duplicate key, first match wins
   task automatic test_fill_and_replace();
      logic [KEY_W-1:0] k;
      for (int i = 0; i < LINES-2; i++) begin
         k = (i == 0) ? KEY_ONES : {$urandom, $urandom};
         send_request(CMD_INSERT, k, SIZE_W'($urandom_range(0, MAX_SIZE_RESET)));
      end
      send_request(CMD_INSERT, 64'h1, 20'd7);
      send_request(CMD_INSERT, KEY_ONES, 20'd100);
      send_request(CMD_LOOKUP, KEY_ONES, '0);
      send_request(CMD_LOOKUP, '0, '0);
      send_request(CMD_LOOKUP, 64'h1, SIZE_ONES);
      send_request(CMD_INSERT, 64'h8000_0000_0000_0000, 20'h80000);
   endtask

   // limit at both extremes, and a write to an undecoded index
   task automatic test_limit_extremes();
      write_register(REG_MAX_SIZE, 32'hFFF0_0000);
      send_request(CMD_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, '0);
      send_request(CMD_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 20'd1);
      write_register(REG_MAX_SIZE, 32'(SIZE_ONES));
      send_request(CMD_INSERT, 64'hC3C3_C3C3_C3C3_C3C3, SIZE_ONES);
      write_register(REG_UNUSED, 32'h0);
      send_request(CMD_INSERT, 64'h3C3C_3C3C_3C3C_3C3C, SIZE_ONES);
   endtask

   // random traffic over several limit settings
   task automatic test_random_traffic();
      logic [SIZE_W-1:0] lim;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       lim = SIZE_ONES;
            1:       lim = SIZE_W'($urandom);
            2:       lim = MAX_SIZE_RESET;
            3:       lim = 20'd16;
            default: lim = '0;
         endcase
         write_register(REG_MAX_SIZE, {12'($urandom), lim});
         refill_pool();
         run_traffic(250);
      end
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_output_stall();
      write_register(REG_MAX_SIZE, 32'(SIZE_ONES));
      refill_pool();
      stall_request = LONG_HOLD;
      gapless = 1;
      run_traffic(40);
      gapless = 0;
   endtask

   // main sequence
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_LOOKUP;
      req_ch.key         <= '0;
      req_ch.object_size <= '0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      for (int i = 0; i < LINES; i++) begin
         tag_valid[i] = 1'b0;
         tag_key[i]   = '0;
         tag_stamp[i] = '0;
         tag_size[i]  = '0;
      end
      stamp_count = '0;
      size_limit  = MAX_SIZE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_reset_limit();
      test_fill_and_replace();
      test_limit_extremes();
      test_output_stall();
      test_random_traffic();

      wait_idle();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // receiver: checks each result, then picks the next ready
   initial begin
      int          hold_left;
      int          mode_left;
      int          tick;
      rx_mode_type mode;
      outcome_type want;
      outcome_type got;
      logic        next_ready;
      hold_left = 0;
      mode_left = 0;
      tick      = 0;
      mode      = RX_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.hit, rsp_ch.line, rsp_ch.stored_size, rsp_ch.accepted,
                    rsp_ch.evicted};
            if (pending_results.size() == 0) begin
               flag_error($sformatf("result with nothing expected: %s", fmt_outcome(got)));
            end else begin
               want = pending_results.pop_front();
               if (got.hit !== want.hit || got.line !== want.line ||
                   got.stored_size !== want.stored_size || got.accepted !== want.accepted ||
                   got.evicted !== want.evicted)
                  flag_error($sformatf("expected %s, got %s", fmt_outcome(want),
                                       fmt_outcome(got)));
            end
         end
         if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
         end
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            if (mode_left <= 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
               RX_OPEN:     next_ready = 1'b1;
               RX_COIN:     next_ready = 1'($urandom_range(0, 1));
               RX_PERIODIC: next_ready = (tick % 7) >= 3;
               default:     next_ready = ($urandom_range(0, 4) == 0);
            endcase
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule : testbench
